// ===== rtl/mci_pkg.sv =====
package mci_pkg;

	typedef enum logic [1:0] {
		FUNC_CLEAR   = 2'd0,
		FUNC_INSERT  = 2'd1,
		FUNC_CONVERT = 2'd2,
		FUNC_NONE    = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_SCAN,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_PUT,
		ST_RD_PREV,
		ST_WAIT_PREV,
		ST_MUL,
		ST_DIV_START,
		ST_DIV,
		ST_FINISH,
		ST_OUT
	} state_t;

	localparam int KEY_W = 16;
	localparam int VAL_W = 32;
	localparam int DIFF_W = 33;
	localparam int PROD_W = KEY_W + 1 + DIFF_W;
	localparam int TDATA_IN_W = 56;
	localparam int TDATA_OUT_W = 40;

	typedef struct packed {
		logic                     start;
		logic signed [PROD_W-1:0] num;
		logic        [KEY_W-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [PROD_W-1:0] quot;
	} div_rsp_t;

endpackage

// ===== rtl/meter_calibration_interpolator.sv =====
// channel | dir | fields (tdata/tuser, lsb first)
// s_axis  | in  | tdata: func[1:0] meter_index[5:2] raw_reading[21:6] point_value[53:22]
// m_axis  | out | tdata: calibrated_value[31:0] status[32]
// clear zeroes the meter's point count; insert scans the stored points, shifts
// larger ones up a slot and writes the new point; convert scans the table
// point by point, then runs a bit-serial divide
// reset clears all point counts at once; tables hold no reset
// s_axis_tready is low while an item is in work; a result holds until taken
module meter_calibration_interpolator
	import mci_pkg::*;
#(
	parameter int NUM_METERS = 16,
	parameter int POINTS_PER_METER = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [TDATA_IN_W-1:0]  s_axis_tdata,  // func, meter_index, raw_reading, point_value
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [TDATA_OUT_W-1:0] m_axis_tdata   // calibrated_value, status
);

	localparam int MI_W = (NUM_METERS > 1) ? $clog2(NUM_METERS) : 1;
	localparam int PI_W = $clog2(POINTS_PER_METER);
	localparam int CNT_W = $clog2(POINTS_PER_METER + 1);
	localparam int ADDR_W = MI_W + PI_W;
	localparam int DEPTH = NUM_METERS * POINTS_PER_METER;

	logic [KEY_W-1:0] key_mem [DEPTH];
	logic [VAL_W-1:0] val_mem [DEPTH];
	logic [CNT_W-1:0] cnt_q [NUM_METERS];

	state_t state_q, state_d;
	func_t  func_q;
	logic [MI_W-1:0]  meter_q;
	logic             mvalid_q;
	logic [KEY_W-1:0] raw_q;
	logic [VAL_W-1:0] pv_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] sh_q;
	logic [KEY_W-1:0] rk_q;
	logic [VAL_W-1:0] rv_q;
	logic [KEY_W-1:0] k1_q;
	logic [VAL_W-1:0] v1_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [VAL_W-1:0] res_q;
	logic             stat_q;
	logic             ovalid_q;

	logic [ADDR_W-1:0] rd_addr;
	logic              rd_en;
	logic [ADDR_W-1:0] wr_addr;
	logic              wr_en;
	logic [KEY_W-1:0]  wr_key;
	logic [VAL_W-1:0]  wr_val;

	div_req_t dreq;
	div_rsp_t drsp;

	logic                    in_fire;
	logic [1:0]              in_func;
	logic [3:0]              in_meter;
	logic signed [DIFF_W-1:0] dv;
	logic [KEY_W:0]          dk;
	logic signed [DIFF_W:0]  sum_res;

	assign in_func  = s_axis_tdata[1:0];
	assign in_meter = s_axis_tdata[5:2];
	assign s_axis_tready = (state_q == ST_IDLE) && !ovalid_q;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	function automatic logic [ADDR_W-1:0] addr_of(logic [MI_W-1:0] m, logic [CNT_W-1:0] p);
		logic [ADDR_W-1:0] a;
		a = ADDR_W'(m) * ADDR_W'(POINTS_PER_METER) + ADDR_W'(p);
		return a;
	endfunction

	mci_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign dv = $signed({v1_q[VAL_W-1], v1_q}) - $signed({rv_q[VAL_W-1], rv_q});
	assign dk = {1'b0, k1_q} - {1'b0, raw_q};
	assign dreq.start = (state_q == ST_DIV_START);
	assign dreq.num = prod_q;
	assign dreq.den = k1_q - rk_q;
	assign sum_res = $signed({v1_q[VAL_W-1], v1_q[VAL_W-1], v1_q})
		- $signed(drsp.quot[DIFF_W:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		rd_en = 1'b0;
		rd_addr = addr_of(meter_q, pos_q);
		wr_en = 1'b0;
		wr_addr = addr_of(meter_q, pos_q);
		wr_key = raw_q;
		wr_val = pv_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire)
					state_d = ST_RD;
			end
			ST_RD: begin
				if (!mvalid_q || func_q == FUNC_CLEAR || func_q == FUNC_NONE)
					state_d = ST_OUT;
				else if (func_q == FUNC_CONVERT && n_q == '0)
					state_d = ST_OUT;
				else if (func_q == FUNC_INSERT && n_q == '0)
					state_d = ST_PUT;
				else begin
					rd_en = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (rk_q < raw_q && pos_q + 1'b1 < n_q) begin
					rd_en = 1'b1;
					rd_addr = addr_of(meter_q, pos_q + 1'b1);
				end else if (func_q == FUNC_INSERT) begin
					if (rk_q == raw_q) begin
						wr_en = 1'b1;
						state_d = ST_OUT;
					end else if (n_q == CNT_W'(POINTS_PER_METER))
						state_d = ST_OUT;
					else if (rk_q < raw_q)
						state_d = ST_PUT;
					else if (n_q == pos_q)
						state_d = ST_PUT;
					else begin
						rd_en = 1'b1;
						rd_addr = addr_of(meter_q, n_q - 1'b1);
						state_d = ST_SHIFT_WR;
					end
				end else begin
					if (rk_q < raw_q || pos_q == '0)
						state_d = ST_OUT;
					else begin
						rd_en = 1'b1;
						rd_addr = addr_of(meter_q, pos_q - 1'b1);
						state_d = ST_WAIT_PREV;
					end
				end
			end
			ST_SHIFT_RD: begin
				rd_en = 1'b1;
				rd_addr = addr_of(meter_q, sh_q - 1'b1);
				state_d = ST_SHIFT_WR;
			end
			ST_SHIFT_WR: begin
				wr_en = 1'b1;
				wr_addr = addr_of(meter_q, sh_q);
				wr_key = rk_q;
				wr_val = rv_q;
				state_d = (sh_q - 1'b1 == pos_q) ? ST_PUT : ST_SHIFT_RD;
			end
			ST_PUT: begin
				wr_en = 1'b1;
				state_d = ST_OUT;
			end
			ST_WAIT_PREV: state_d = ST_MUL;
			ST_MUL: state_d = ST_DIV_START;
			ST_DIV_START: state_d = ST_DIV;
			ST_DIV: begin
				if (drsp.done)
					state_d = ST_FINISH;
			end
			ST_FINISH: state_d = ST_OUT;
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rk_q <= key_mem[rd_addr];
			rv_q <= val_mem[rd_addr];
		end
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			val_mem[wr_addr] <= wr_val;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					func_q   <= func_t'(in_func);
					meter_q  <= MI_W'(in_meter);
					mvalid_q <= 32'(in_meter) < NUM_METERS;
					raw_q    <= s_axis_tdata[21:6];
					pv_q     <= s_axis_tdata[53:22];
					n_q      <= (32'(in_meter) < NUM_METERS) ? cnt_q[MI_W'(in_meter)] : '0;
					pos_q    <= '0;
					stat_q   <= 1'b0;
				end
			end
			ST_RD: begin
				sh_q <= n_q;
				if (func_q == FUNC_CONVERT && n_q == '0)
					res_q <= raw_q[KEY_W-1] ? 32'h7FFF_FFFF : {raw_q, 16'h0};
				else
					res_q <= '0;
			end
			ST_SCAN: begin
				if (rk_q < raw_q && pos_q + 1'b1 < n_q)
					pos_q <= pos_q + 1'b1;
				else if (func_q == FUNC_INSERT) begin
					if (rk_q != raw_q && n_q == CNT_W'(POINTS_PER_METER))
						stat_q <= 1'b1;
					if (rk_q < raw_q)
						pos_q <= n_q;
				end else begin
					res_q <= rv_q;
					k1_q  <= rk_q;
					v1_q  <= rv_q;
				end
			end
			ST_SHIFT_WR: sh_q <= sh_q - 1'b1;
			ST_MUL: prod_q <= $signed({1'b0, dk}) * dv;
			ST_FINISH: res_q <= sum_res[VAL_W-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_METERS; i++)
				cnt_q[i] <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (state_q == ST_RD && mvalid_q && func_q == FUNC_CLEAR)
				cnt_q[meter_q] <= '0;
			if (state_q == ST_PUT)
				cnt_q[meter_q] <= n_q + 1'b1;
			if (state_q == ST_OUT)
				ovalid_q <= 1'b1;
			else if (m_axis_tready)
				ovalid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = {7'b0, stat_q, res_q};

endmodule

// ===== rtl/mci_divider.sv =====
module mci_divider
	import mci_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(PROD_W + 1);

	logic [KEY_W-1:0]   rem_q;
	logic [PROD_W-1:0]  quo_q;
	logic [KEY_W-1:0]   den_q;
	logic               neg_q;
	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [KEY_W:0]     trial;
	logic [PROD_W-1:0]  mag;
	logic [KEY_W:0]     sub;

	assign mag = req.num[PROD_W-1] ? PROD_W'(-req.num) : PROD_W'(req.num);
	assign trial = {rem_q, quo_q[PROD_W-1]};
	assign sub = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(PROD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= mag;
			den_q <= req.den;
			neg_q <= req.num[PROD_W-1];
		end else if (busy_q) begin
			if (!sub[KEY_W]) begin
				rem_q <= sub[KEY_W-1:0];
				quo_q <= {quo_q[PROD_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[KEY_W-1:0];
				quo_q <= {quo_q[PROD_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

// ===== rtl/mci_checker.sv =====
module mci_checker
	import mci_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic [TDATA_IN_W-1:0]  s_axis_tdata,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [TDATA_OUT_W-1:0] m_axis_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("ready after accept");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input ready while result pending");

	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[31:0] == 32'd0)
		else $error("dropped insert with nonzero value");

endmodule

bind meter_calibration_interpolator mci_checker u_mci_checker (.*);
